// ===== src/xyz_bounding_box_accumulator_unit_assert.svh =====
// assertion macros for the bounding box accumulator
// used by the top level only
`ifndef XYZ_BOUNDING_BOX_ACCUMULATOR_UNIT_ASSERT_SVH
`define XYZ_BOUNDING_BOX_ACCUMULATOR_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define XBB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define XBB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/xbb_pkg.sv =====
// shared constants and compare helpers for the bounding box accumulator
// no dependencies
package xbb_pkg;

    localparam int unsigned W = 64;
    typedef logic [W-1:0] t_dbl;

    localparam t_dbl POS_INF = 64'h7FF0_0000_0000_0000;
    localparam t_dbl NEG_INF = 64'hFFF0_0000_0000_0000;
    localparam t_dbl NA_VAL  = 64'h7FF0_0000_0000_07A2;

    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_SKIP   = 2'd1,
        MODE_FINITE = 2'd2
    } t_mode;

    function automatic logic is_nan(input t_dbl b);
        return b[62:0] > POS_INF[62:0];
    endfunction

    function automatic logic is_inf(input t_dbl b);
        return b[62:0] == POS_INF[62:0];
    endfunction

    // a < b as doubles, neither NaN
    function automatic logic dbl_lt(input t_dbl a, input t_dbl b);
        logic lt;
        if (a[62:0] == 63'd0 && b[62:0] == 63'd0) begin
            lt = 1'b0;
        end else if (a[63] != b[63]) begin
            lt = a[63];
        end else if (a[63]) begin
            lt = a[62:0] > b[62:0];
        end else begin
            lt = a[62:0] < b[62:0];
        end
        return lt;
    endfunction

endpackage

// ===== src/xbb_fold.sv =====
// one extent update: fold a coordinate into a stored min or max
// depends on xbb_pkg
module xbb_fold (
    input  xbb_pkg::t_dbl  i_stored,
    input  xbb_pkg::t_dbl  i_coord,
    input  xbb_pkg::t_mode i_mode,
    input  logic           i_want_max,
    output xbb_pkg::t_dbl  o_result
);
    import xbb_pkg::*;

    logic s_bad, v_bad, take_v;

    always_comb begin
        s_bad = is_nan(i_stored) || (i_mode == MODE_FINITE && is_inf(i_stored));
        v_bad = is_nan(i_coord) || (i_mode == MODE_FINITE && is_inf(i_coord));
        take_v = i_want_max ? dbl_lt(i_stored, i_coord) : dbl_lt(i_coord, i_stored);
        if (i_mode == MODE_PLAIN) begin
            o_result = (s_bad || v_bad) ? NA_VAL : (take_v ? i_coord : i_stored);
        end else if (s_bad && v_bad) begin
            o_result = i_want_max ? NEG_INF : POS_INF;
        end else if (s_bad) begin
            o_result = i_coord;
        end else if (v_bad) begin
            o_result = i_stored;
        end else begin
            o_result = take_v ? i_coord : i_stored;
        end
    end

endmodule

// ===== src/xyz_bounding_box_accumulator_unit.sv =====
// Running x/y/z bounding box of a stream of points given as double bit patterns.
// Input channel: i_valid / o_stall with coordinates, restart and null flags.
// Output channel: o_valid / i_stall with the six extents after each point.
// Each accepted point yields exactly one word, registered and shown in the cycle after acceptance.
// Throughput is one point per cycle while o_stall is low: the six compare-and-select units work in
// the cycle of acceptance and the extent registers feed back to themselves.
// The output register holds one word; o_stall rises only while that word
// waits and the receiver stalls, and a new point is accepted in the same
// cycle the held word is taken.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_data; index 0 na_remove,
// index 1 finite_only (overrides na_remove when folding points). Write only while idle.
// Reset (synchronous, active low) sets mins to +inf, maxes to -inf, clears
// both mode bits and empties the output register.
// Restart folds the point into +inf/-inf; a null point sets all extents to
// +inf/-inf under na_remove, else to NA.
// depends on xbb_pkg, xbb_fold and the assertion macro header
`include "xyz_bounding_box_accumulator_unit_assert.svh"
module xyz_bounding_box_accumulator_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  xbb_pkg::t_dbl i_x_bits,
    input  xbb_pkg::t_dbl i_y_bits,
    input  xbb_pkg::t_dbl i_z_bits,
    input  logic          i_restart_feature,
    input  logic          i_null_feature,
    output logic          o_valid,
    input  logic          i_stall,
    output xbb_pkg::t_dbl o_min_x,
    output xbb_pkg::t_dbl o_min_y,
    output xbb_pkg::t_dbl o_min_z,
    output xbb_pkg::t_dbl o_max_x,
    output xbb_pkg::t_dbl o_max_y,
    output xbb_pkg::t_dbl o_max_z,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic          i_cfg_data
);
    import xbb_pkg::*;

    localparam logic CFG_NA_REMOVE   = 1'b0;
    localparam logic CFG_FINITE_ONLY = 1'b1;

    logic  r_na_remove, r_finite_only, r_valid;
    t_dbl  r_lo [3];
    t_dbl  r_hi [3];
    t_dbl  n_lo [3];
    t_dbl  n_hi [3];
    t_dbl  base_lo [3];
    t_dbl  base_hi [3];
    t_dbl  fold_lo [3];
    t_dbl  fold_hi [3];
    t_dbl  coord [3];
    t_mode mode;
    logic  accept;

    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign mode    = r_finite_only ? MODE_FINITE : (r_na_remove ? MODE_SKIP : MODE_PLAIN);
    assign coord[0] = i_x_bits;
    assign coord[1] = i_y_bits;
    assign coord[2] = i_z_bits;

    for (genvar g = 0; g < 3; g++) begin : g_axis
        assign base_lo[g] = i_restart_feature ? POS_INF : r_lo[g];
        assign base_hi[g] = i_restart_feature ? NEG_INF : r_hi[g];
        xbb_fold u_lo (.i_stored(base_lo[g]), .i_coord(coord[g]), .i_mode(mode),
                       .i_want_max(1'b0), .o_result(fold_lo[g]));
        xbb_fold u_hi (.i_stored(base_hi[g]), .i_coord(coord[g]), .i_mode(mode),
                       .i_want_max(1'b1), .o_result(fold_hi[g]));
        always_comb begin
            if (i_null_feature) begin
                n_lo[g] = r_na_remove ? POS_INF : NA_VAL;
                n_hi[g] = r_na_remove ? NEG_INF : NA_VAL;
            end else begin
                n_lo[g] = fold_lo[g];
                n_hi[g] = fold_hi[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_na_remove   <= 1'b0;
            r_finite_only <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_lo[k] <= POS_INF;
                r_hi[k] <= NEG_INF;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_NA_REMOVE:   r_na_remove   <= i_cfg_data;
                    CFG_FINITE_ONLY: r_finite_only <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_valid <= 1'b1;
                for (int k = 0; k < 3; k++) begin
                    r_lo[k] <= n_lo[k];
                    r_hi[k] <= n_hi[k];
                end
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_min_x = r_lo[0];
    assign o_min_y = r_lo[1];
    assign o_min_z = r_lo[2];
    assign o_max_x = r_hi[0];
    assign o_max_y = r_hi[1];
    assign o_max_z = r_hi[2];

    `XBB_ASSERT_NEXT(a_accept_gives_word, i_clk, i_rst_n, accept, o_valid,
        "accepted point did not produce a word")
    `XBB_ASSERT_IMP(a_stall_only_when_full, i_clk, i_rst_n, o_stall, o_valid && i_stall,
        "input stalled without a waiting word")
    `XBB_ASSERT_NEXT(a_held_extents, i_clk, i_rst_n, o_valid && i_stall,
        $stable(o_min_x) && $stable(o_max_z), "held word changed under stall")
    `XBB_ASSERT_NEXT(a_null_na, i_clk, i_rst_n,
        accept && i_null_feature && !r_na_remove, o_min_x == NA_VAL && o_max_y == NA_VAL,
        "null point without na_remove must give NA")

endmodule
